/* hdl/assert_macros.svh */
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is asserted.
`define FDAL_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define FDAL_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* hdl/fdal_pkg.sv */
package fdal_pkg;

	// Input item and result item
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic [7:0] query_addr;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] frame_byte;
		logic       first_byte;
		logic       last_byte;
		logic       owned;
	} out_item_t;

	localparam logic [1:0] OP_BYTE     = 2'd0;
	localparam logic [1:0] OP_QUERY    = 2'd1;
	localparam logic [1:0] OP_LINK_RST = 2'd2;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_DROP  = 2'd1;
	localparam logic [1:0] KIND_ABORT = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	localparam logic [7:0] MAGIC_M = 8'h4D;
	localparam logic [7:0] MAGIC_H = 8'h48;

	localparam int           LEN_SUM_W = 17;
	localparam logic [15:0]  MIN_LEN   = 16'd8;
	localparam logic [16:0]  HDR_EXTRA = 17'd6;
	localparam logic [7:0]   SRC_OFFS  = 8'd6;
	localparam int           MIN_TOTAL = 14;

	// Up to four results per input beat
	localparam int MAX_RES   = 4;
	localparam int RES_CNT_W = 3;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = 3;
	localparam int FIFO_CNT_W = 4;

	typedef struct packed {
		logic [RES_CNT_W-1:0]      n;
		out_item_t [MAX_RES-1:0]   item;
	} res_bundle_t;

	typedef struct packed {
		logic       clr;
		logic       learn;
		logic [7:0] addr;
	} tbl_cmd_t;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNASSIGNED    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOST          = 2'd2;

	localparam logic [10:0] MAX_FRAME_LEN_RST = 11'd1024;
	localparam logic [7:0]  UNASSIGNED_RST    = 8'd0;
	localparam logic [7:0]  HOST_RST          = 8'd1;

endpackage

/* hdl/fdal_addr_tbl.sv */
`include "assert_macros.svh"

module fdal_addr_tbl #(
	parameter int ADDR_ENTRIES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  fdal_pkg::tbl_cmd_t cmd,
	input  logic [7:0]       unassigned_addr,
	input  logic [7:0]       host_addr,
	input  logic [7:0]       query_addr,
	output logic             query_hit
);

	localparam int CNT_W = $clog2(ADDR_ENTRIES + 1);
	localparam int IDX_W = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;

	logic [7:0]       tbl_q [ADDR_ENTRIES];
	logic [CNT_W-1:0] cnt_q;
	logic             learn_hit;
	logic             learn_ok;

	// Compare every held entry in parallel
	always_comb begin
		query_hit = 1'b0;
		learn_hit = 1'b0;
		for (int i = 0; i < ADDR_ENTRIES; i++) begin
			if (CNT_W'(i) < cnt_q) begin
				if (tbl_q[i] == query_addr) query_hit = 1'b1;
				if (tbl_q[i] == cmd.addr)   learn_hit = 1'b1;
			end
		end
	end

	assign learn_ok = cmd.learn && !learn_hit && (cmd.addr != unassigned_addr) &&
		(cmd.addr != host_addr) && (cnt_q < CNT_W'(ADDR_ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr) begin
			cnt_q <= '0;
		end else if (learn_ok) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (learn_ok && !cmd.clr) begin
			tbl_q[cnt_q[IDX_W-1:0]] <= cmd.addr;
		end
	end

	`FDAL_ASSERT(a_tbl_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(ADDR_ENTRIES), "table fill overrun")

endmodule

/* hdl/fdal_parse.sv */
`include "assert_macros.svh"

module fdal_parse #(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  fdal_pkg::in_item_t    req,
	input  logic [10:0]           max_frame_len,
	input  logic                  query_hit,
	output fdal_pkg::res_bundle_t res,
	output fdal_pkg::tbl_cmd_t    tbl_cmd
);

	localparam int TOT_W = $clog2(BUFFER_BYTES + 1);

	localparam int RES_CNT_W = fdal_pkg::RES_CNT_W;
	localparam int MAX_RES   = fdal_pkg::MAX_RES;
	localparam int LEN_SUM_W = fdal_pkg::LEN_SUM_W;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_GOT_M  = 3'd1;
	localparam logic [2:0] PH_GOT_MH = 3'd2;
	localparam logic [2:0] PH_GOT_LO = 3'd3;
	localparam logic [2:0] PH_PASS   = 3'd4;
	localparam logic [2:0] PH_SKIP   = 3'd5;

	logic [2:0]       phase_q, phase_n;
	logic [7:0]       len_low_q, len_low_n;
	logic [TOT_W-1:0] frame_total_q, frame_total_n;
	logic [TOT_W-1:0] bytes_seen_q, bytes_seen_n;
	logic [7:0]       source_q, source_n;

	always_comb begin
		logic [15:0]          len;
		logic [LEN_SUM_W-1:0] total;
		logic [TOT_W-1:0]     seen_inc;
		logic [7:0]           src;
		logic [2:0]           p1;
		logic [7:0]           b;

		b        = req.data_byte;
		len      = {b, len_low_q};
		total    = {1'b0, len} + fdal_pkg::HDR_EXTRA;
		seen_inc = bytes_seen_q + TOT_W'(1);
		src      = (bytes_seen_q == TOT_W'(fdal_pkg::SRC_OFFS)) ? b : source_q;
		p1       = (len_low_q == fdal_pkg::MAGIC_M) ? PH_GOT_M : PH_HUNT;

		phase_n       = phase_q;
		len_low_n     = len_low_q;
		frame_total_n = frame_total_q;
		bytes_seen_n  = bytes_seen_q;
		source_n      = source_q;
		res           = '0;
		tbl_cmd       = '0;
		tbl_cmd.addr  = src;

		if (accept) begin
			unique case (req.op)
				fdal_pkg::OP_BYTE: begin
					unique case (phase_q)
						PH_PASS: begin
							res.n                  = RES_CNT_W'(1);
							res.item[0].kind       = fdal_pkg::KIND_FRAME;
							res.item[0].frame_byte = b;
							source_n               = src;
							bytes_seen_n           = seen_inc;
							if (seen_inc >= frame_total_q) begin
								res.item[0].last_byte = 1'b1;
								tbl_cmd.learn         = 1'b1;
								phase_n               = PH_HUNT;
								len_low_n             = '0;
								frame_total_n         = '0;
								bytes_seen_n          = '0;
								source_n              = '0;
							end
						end
						PH_SKIP: begin
							bytes_seen_n = seen_inc;
							if (seen_inc >= frame_total_q) begin
								res.n            = RES_CNT_W'(1);
								res.item[0].kind = fdal_pkg::KIND_DROP;
								phase_n          = PH_HUNT;
								len_low_n        = '0;
								frame_total_n    = '0;
								bytes_seen_n     = '0;
								source_n         = '0;
							end
						end
						PH_GOT_LO: begin
							if (len < fdal_pkg::MIN_LEN ||
								total > LEN_SUM_W'(BUFFER_BYTES)) begin
								// False start: rescan both length bytes
								if (p1 == PH_GOT_M && b == fdal_pkg::MAGIC_H) begin
									phase_n = PH_GOT_MH;
								end else begin
									phase_n = (b == fdal_pkg::MAGIC_M) ? PH_GOT_M : PH_HUNT;
								end
							end else begin
								frame_total_n = total[TOT_W-1:0];
								bytes_seen_n  = TOT_W'(MAX_RES);
								if (total > LEN_SUM_W'(max_frame_len)) begin
									phase_n = PH_SKIP;
								end else begin
									phase_n                = PH_PASS;
									res.n                  = RES_CNT_W'(MAX_RES);
									res.item[0].kind       = fdal_pkg::KIND_FRAME;
									res.item[0].frame_byte = fdal_pkg::MAGIC_M;
									res.item[0].first_byte = 1'b1;
									res.item[1].kind       = fdal_pkg::KIND_FRAME;
									res.item[1].frame_byte = fdal_pkg::MAGIC_H;
									res.item[2].kind       = fdal_pkg::KIND_FRAME;
									res.item[2].frame_byte = len_low_q;
									res.item[3].kind       = fdal_pkg::KIND_FRAME;
									res.item[3].frame_byte = b;
								end
							end
						end
						PH_GOT_MH: begin
							len_low_n = b;
							phase_n   = PH_GOT_LO;
						end
						PH_GOT_M: begin
							if (b == fdal_pkg::MAGIC_H) begin
								phase_n = PH_GOT_MH;
							end else begin
								phase_n = (b == fdal_pkg::MAGIC_M) ? PH_GOT_M : PH_HUNT;
							end
						end
						default: begin
							phase_n = (b == fdal_pkg::MAGIC_M) ? PH_GOT_M : PH_HUNT;
						end
					endcase
				end
				fdal_pkg::OP_QUERY: begin
					res.n             = RES_CNT_W'(1);
					res.item[0].kind  = fdal_pkg::KIND_QUERY;
					res.item[0].owned = query_hit;
				end
				fdal_pkg::OP_LINK_RST: begin
					if (phase_q == PH_PASS) begin
						res.n            = RES_CNT_W'(1);
						res.item[0].kind = fdal_pkg::KIND_ABORT;
					end
					tbl_cmd.clr   = 1'b1;
					phase_n       = PH_HUNT;
					len_low_n     = '0;
					frame_total_n = '0;
					bytes_seen_n  = '0;
					source_n      = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			len_low_q     <= '0;
			frame_total_q <= '0;
			bytes_seen_q  <= '0;
			source_q      <= '0;
		end else begin
			phase_q       <= phase_n;
			len_low_q     <= len_low_n;
			frame_total_q <= frame_total_n;
			bytes_seen_q  <= bytes_seen_n;
			source_q      <= source_n;
		end
	end

	`FDAL_ASSERT(a_pass_in_frame, clk, arst_n, (phase_q == PH_PASS || phase_q == PH_SKIP) |-> (bytes_seen_q < frame_total_q), "byte count past frame end")
	`FDAL_ASSERT(a_total_min, clk, arst_n, (phase_q == PH_PASS || phase_q == PH_SKIP) |-> (frame_total_q >= TOT_W'(fdal_pkg::MIN_TOTAL)), "frame total below minimum")
	`FDAL_ASSERT(a_learn_excl, clk, arst_n, !(tbl_cmd.clr && tbl_cmd.learn), "learn during table clear")

endmodule

/* hdl/fdal_res_fifo.sv */
`include "assert_macros.svh"

module fdal_res_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdal_pkg::res_bundle_t push,
	output logic                  room,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output fdal_pkg::out_item_t   rsp
);

	localparam int DEPTH = fdal_pkg::FIFO_DEPTH;
	localparam int PTR_W = fdal_pkg::FIFO_PTR_W;
	localparam int CNT_W = fdal_pkg::FIFO_CNT_W;
	localparam int MAXR  = fdal_pkg::MAX_RES;

	fdal_pkg::out_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                pop;

	assign rsp_valid = (cnt_q != '0);
	assign rsp       = mem_q[rd_q];
	assign pop       = rsp_valid && rsp_ready;
	// Take a beat only when a full header burst still fits
	assign room      = (cnt_q <= CNT_W'(DEPTH - MAXR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAXR; i++) begin
			if (fdal_pkg::RES_CNT_W'(i) < push.n) begin
				mem_q[wr_q + PTR_W'(i)] <= push.item[i];
			end
		end
	end

	`FDAL_ASSERT(a_fifo_bound, clk, arst_n, cnt_q <= CNT_W'(DEPTH), "result queue overrun")
	`FDAL_ASSERT(a_push_room, clk, arst_n, (push.n != '0) |-> room, "burst pushed without room")

endmodule

/* hdl/frame_deframer_addr_learn.sv */
// Byte-stream deframer with source address learning.
// Request channel (req_valid/req_ready/req): one beat per item, either a
// stream byte, an address query or a link reset. Response channel
// (rsp_valid/rsp_ready/rsp): frame bytes with first/last marks, oversize
// drop and abort notices, and query answers.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; write it only while the block is idle.
// Throughput: one request beat per cycle while req_ready is high. A
// stream byte that completes a good header within the maximum frame
// length yields four response beats at once; the result queue drains
// one beat per cycle while rsp_ready is high, so the response port
// sets the sustained rate. Each result queues behind beats already held.
// Reset: parser hunts for the magic, the address table is empty, and the
// registers return to max length 1024, unassigned 0, host 1.
// Stall: the eight-entry result queue holds beats while rsp_ready is low;
// req_ready drops once fewer than four slots are free.
module frame_deframer_addr_learn #(
	parameter int BUFFER_BYTES = 1024,
	parameter int ADDR_ENTRIES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  fdal_pkg::in_item_t                  req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output fdal_pkg::out_item_t                 rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fdal_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdal_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [10:0]           max_frame_len_q;
	logic [7:0]            unassigned_q;
	logic [7:0]            host_q;
	logic                  accept;
	logic                  query_hit;
	fdal_pkg::res_bundle_t res;
	fdal_pkg::tbl_cmd_t    tbl_cmd;

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && req_ready;

	// Register writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= fdal_pkg::MAX_FRAME_LEN_RST;
			unassigned_q    <= fdal_pkg::UNASSIGNED_RST;
			host_q          <= fdal_pkg::HOST_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fdal_pkg::REG_MAX_FRAME_LEN: max_frame_len_q <= cfg_data[10:0];
				fdal_pkg::REG_UNASSIGNED:    unassigned_q    <= cfg_data[7:0];
				fdal_pkg::REG_HOST:          host_q          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Header hunt, pass/skip tracking and result building
	fdal_parse #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req           (req),
		.max_frame_len (max_frame_len_q),
		.query_hit     (query_hit),
		.res           (res),
		.tbl_cmd       (tbl_cmd)
	);

	// Learned source addresses
	fdal_addr_tbl #(
		.ADDR_ENTRIES(ADDR_ENTRIES)
	) u_addr_tbl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (tbl_cmd),
		.unassigned_addr (unassigned_q),
		.host_addr       (host_q),
		.query_addr      (req.query_addr),
		.query_hit       (query_hit)
	);

	// Hold results until the receiver takes them
	fdal_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.room      (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
